// File: hw/rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACE = 8;
  localparam int JOB_BYTES   = 8;

  typedef struct packed {
    logic [JOB_BYTES*8-1:0] data;
    logic [3:0]             cnt;
    logic                   last;
  } job_t;

endpackage

// File: hw/rtl/sfr_front.sv
`timescale 1ns / 1ps

module sfr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic [7:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  input  logic          in_accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          job_push,
  output sfr_pkg::job_t job
);
  import sfr_pkg::*;

  localparam logic [7:0] REG_PAT_LEN   = 8'd0;
  localparam logic [7:0] REG_PAT_BYTES = 8'd1;
  localparam logic [7:0] REG_REP_LEN   = 8'd2;
  localparam logic [7:0] REG_REP_BYTES = 8'd3;

  logic [3:0]  pattern_length_r;
  logic [63:0] pattern_bytes_r;
  logic [3:0]  replace_length_r;
  logic [63:0] replace_bytes_r;

  logic [7:0]  win_r [MAX_PATTERN-1];
  logic [7:0]  win_nxt [MAX_PATTERN-1];
  logic [2:0]  win_cnt_r;
  logic [2:0]  win_cnt_nxt;

  logic [3:0]  pat_len_eff;
  logic [3:0]  rep_len_eff;
  logic [3:0]  lim;
  logic [2:0]  n0;
  logic [3:0]  n;
  logic [7:0]  buf_b [MAX_PATTERN];
  logic [MAX_PATTERN*8-1:0] buf_w;
  logic [MAX_PATTERN*8-1:0] shifted;
  logic [MAX_PATTERN-1:0]   pre;
  logic [MAX_PATTERN-1:0]   ok;
  logic [3:0]  s_stop;
  logic        full;
  logic        cfg_hit;

  always_comb begin
    pat_len_eff = pattern_length_r;
    if (pattern_length_r == 4'd0) begin
      pat_len_eff = 4'd1;
    end else if (pattern_length_r > 4'(MAX_PATTERN)) begin
      pat_len_eff = 4'(MAX_PATTERN);
    end
    rep_len_eff = (replace_length_r > 4'(MAX_REPLACE)) ? 4'(MAX_REPLACE) : replace_length_r;
    lim = pat_len_eff - 4'd1;
    n0  = ({1'b0, win_cnt_r} > lim) ? lim[2:0] : win_cnt_r;
    n   = {1'b0, n0} + 4'd1;
  end

  // candidate buffer: pending window then the new byte
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      buf_b[k] = 8'h00;
    end
    for (int k = 0; k < MAX_PATTERN - 1; k++) begin
      if (4'(k) < {1'b0, n0}) begin
        buf_b[k] = win_r[k];
      end
    end
    buf_b[n0] = in_byte;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      buf_w[k*8 +: 8] = buf_b[k];
    end
  end

  // pre[s]: buf[s..n-1] matches the pattern head
  always_comb begin
    pre = '1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      for (int s = 0; s <= k; s++) begin
        if ((4'(k) < n) && (buf_b[k] != pattern_bytes_r[(k-s)*8 +: 8])) begin
          pre[s] = 1'b0;
        end
      end
    end
    for (int s = 0; s < MAX_PATTERN; s++) begin
      ok[s] = pre[s] && (4'(s) < n) && ((n - 4'(s)) < pat_len_eff);
    end
    s_stop = n;
    for (int s = MAX_PATTERN - 1; s >= 0; s--) begin
      if (ok[s]) begin
        s_stop = 4'(s);
      end
    end
    full    = (n == pat_len_eff) && pre[0];
    shifted = buf_w >> {s_stop, 3'b000};
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN - 1; k++) begin
      win_nxt[k] = shifted[k*8 +: 8];
    end
    if (full || in_last) begin
      win_cnt_nxt = 3'd0;
    end else begin
      win_cnt_nxt = 3'(n - s_stop);
    end
    if (full) begin
      job.data = replace_bytes_r;
      job.cnt  = rep_len_eff;
    end else begin
      job.data = buf_w;
      job.cnt  = in_last ? n : s_stop;
    end
    job.last = in_last;
    job_push = in_accept && ((job.cnt != 4'd0) || in_last);
  end

  assign cfg_hit = cfg_valid && (cfg_index <= REG_REP_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= 4'd1;
      pattern_bytes_r  <= 64'd0;
      replace_length_r <= 4'd0;
      replace_bytes_r  <= 64'd0;
      win_cnt_r        <= 3'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_PAT_LEN:   pattern_length_r <= cfg_data[3:0];
          REG_PAT_BYTES: pattern_bytes_r  <= cfg_data;
          REG_REP_LEN:   replace_length_r <= cfg_data[3:0];
          REG_REP_BYTES: replace_bytes_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        win_cnt_r <= 3'd0;
      end else if (in_accept) begin
        win_cnt_r <= win_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

// File: hw/rtl/sfr_queue.sv
`timescale 1ns / 1ps

module sfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfr_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          avail,
  output sfr_pkg::job_t head
);
  import sfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return q;
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign avail = (count_r != '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: hw/rtl/sfr_back.sv
`timescale 1ns / 1ps

module sfr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_avail,
  input  sfr_pkg::job_t head,
  output logic          pop,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_end_of_run,
  output logic          out_end_of_text
);
  import sfr_pkg::*;

  logic [2:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       byte_valid_r;
  logic       end_of_run_r;
  logic       end_of_text_r;
  logic       bare;
  logic       final_one;
  logic       load;

  assign bare      = (head.cnt == 4'd0);
  assign final_one = bare || (({1'b0, idx_r} + 4'd1) == head.cnt);
  assign load      = head_avail && (!out_valid_r || !out_stall);
  assign pop       = load && final_one;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= final_one ? 3'd0 : idx_r + 3'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r    <= bare ? 8'h00 : head.data[{idx_r, 3'b000} +: 8];
      byte_valid_r  <= !bare;
      end_of_run_r  <= final_one;
      end_of_text_r <= final_one && head.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_valid  = byte_valid_r;
  assign out_end_of_run  = end_of_run_r;
  assign out_end_of_text = end_of_text_r;

endmodule

// File: hw/rtl/stream_find_replace.sv
// path: accepted item -> job queue -> emitter output register
// throughput: one item per cycle and one result per cycle while out_stall is low;
//   k results of an item hold the emitter; input stalls once the job queue is full
// reset: synchronous rst_n restores the register reset values, empties the window,
//   the job queue and the output register; no clearing pass
`timescale 1ns / 1ps

module stream_find_replace #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_end_of_run,
  output logic        out_end_of_text
);
  import sfr_pkg::*;

  logic in_accept;
  logic job_push;
  job_t job;
  logic q_full;
  logic q_avail;
  job_t q_head;
  logic q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .job_push  (job_push),
    .job       (job)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .full     (q_full),
    .avail    (q_avail),
    .head     (q_head)
  );

  sfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_avail      (q_avail),
    .head            (q_head),
    .pop             (q_pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_run  (out_end_of_run),
    .out_end_of_text (out_end_of_text)
  );

endmodule

// File: hw/rtl/sfr_checker.sv
`timescale 1ns / 1ps

module sfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_byte_valid,
  input logic        out_end_of_run,
  input logic        out_end_of_text
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte) && $stable(out_byte_valid)
      && $stable(out_end_of_run) && $stable(out_end_of_text))
    else $error("stalled result changed");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_end_of_run && out_end_of_text
      && (out_byte == 8'h00))
    else $error("bare marker malformed");

  a_text_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> out_end_of_run)
    else $error("end of text without end of run");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);
